>>> sv/assert_macros.svh
// Assertion macros used by the top level of the Petri net evaluator.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// expr holds in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed: invariant");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

>>> sv/pnete_pkg.sv
// Package of the Petri net enabled-transition evaluator: opcodes, register
// indexes, default sizes and the controller/datapath command types. No dependencies.
package pnete_pkg;

	// default net size
	localparam int DEF_NUM_PLACES      = 16;
	localparam int DEF_NUM_TRANSITIONS = 16;
	localparam int DEF_TOKEN_BITS      = 16;

	// field widths
	localparam int OP_W    = 3;
	localparam int IDX_W   = 4;
	localparam int VALUE_W = 16;
	localparam int VEC_W   = 16;
	localparam int CFG_AW  = 1;
	localparam int CFG_DW  = 16;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;

	// opcodes
	localparam logic [OP_W-1:0] OP_SET_MARK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PRE_WT    = 3'd1;
	localparam logic [OP_W-1:0] OP_INHIBIT   = 3'd2;
	localparam logic [OP_W-1:0] OP_READER    = 3'd3;
	localparam logic [OP_W-1:0] OP_INIT_MARK = 3'd4;
	localparam logic [OP_W-1:0] OP_RESTORE   = 3'd5;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_GUARD_MASK = 1'd0;
	localparam logic [CFG_AW-1:0] REG_EVENT_MASK = 1'd1;

	// controller -> datapath commands
	typedef struct packed {
		logic item_load;   // capture the accepted item
		logic clear;       // clearing sweep write
		logic item_write;  // write the captured item into its store
		logic copy_rd;     // read initial marking for the restore copy
		logic eval_rd;     // read one table entry and its place marking
		logic result_load; // load the output register
	} pnete_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic out_busy;    // output register holds a result not taken this cycle
	} pnete_sts_t;

endpackage

>>> sv/pnete_ctrl.sv
// Sequencer of the evaluator: clearing sweep, item write, restore copy and
// the row/column walk of the tables. Depends on pnete_pkg.
module pnete_ctrl
	import pnete_pkg::*;
#(
	parameter int NUM_PLACES      = DEF_NUM_PLACES,
	parameter int NUM_TRANSITIONS = DEF_NUM_TRANSITIONS,
	localparam int PW = (NUM_PLACES > 1) ? $clog2(NUM_PLACES) : 1,
	localparam int TW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1,
	localparam int LW = (NUM_PLACES * NUM_TRANSITIONS > 1) ?
		$clog2(NUM_PLACES * NUM_TRANSITIONS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_opcode,
	output logic            in_ready,
	input  pnete_sts_t      sts,
	output pnete_cmd_t      cmd,
	output logic [PW-1:0]   place,
	output logic [TW-1:0]   trans,
	output logic [LW-1:0]   lin
);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_WRITE, ST_COPY, ST_SETTLE, ST_EVAL, ST_DRAIN, ST_RESULT
	} state_t;

	localparam logic [PW-1:0] PLACE_LAST = PW'(NUM_PLACES - 1);
	localparam logic [TW-1:0] TRANS_LAST = TW'(NUM_TRANSITIONS - 1);
	localparam logic [LW-1:0] LIN_LAST   = LW'(NUM_PLACES * NUM_TRANSITIONS - 1);

	state_t          state_q;
	logic [PW-1:0]   place_q;
	logic [TW-1:0]   trans_q;
	logic [LW-1:0]   lin_q;
	logic            accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE);
	assign place    = place_q;
	assign trans    = trans_q;
	assign lin      = lin_q;

	// command decode
	always_comb begin
		cmd             = '0;
		cmd.item_load   = accept;
		cmd.clear       = (state_q == ST_CLEAR);
		cmd.item_write  = (state_q == ST_WRITE);
		cmd.copy_rd     = (state_q == ST_COPY);
		cmd.eval_rd     = (state_q == ST_EVAL);
		cmd.result_load = (state_q == ST_RESULT) && !sts.out_busy;
	end

	// state and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			place_q <= '0;
			trans_q <= '0;
			lin_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR, ST_EVAL: begin
					if (lin_q == LIN_LAST) begin
						lin_q   <= '0;
						place_q <= '0;
						trans_q <= '0;
						state_q <= (state_q == ST_CLEAR) ? ST_IDLE : ST_DRAIN;
					end else begin
						lin_q <= lin_q + 1'b1;
						if (place_q == PLACE_LAST) begin
							place_q <= '0;
							trans_q <= (trans_q == TRANS_LAST) ? '0 : trans_q + 1'b1;
						end else begin
							place_q <= place_q + 1'b1;
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_opcode inside {[OP_SET_MARK:OP_INIT_MARK]})
							state_q <= ST_WRITE;
						else if (in_opcode == OP_RESTORE)
							state_q <= ST_COPY;
						else
							state_q <= ST_EVAL;
					end
				end
				ST_WRITE: begin
					state_q <= ST_EVAL;
				end
				ST_COPY: begin
					if (place_q == PLACE_LAST) begin
						place_q <= '0;
						state_q <= ST_SETTLE;
					end else begin
						place_q <= place_q + 1'b1;
					end
				end
				ST_SETTLE: begin
					state_q <= ST_EVAL;
				end
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!sts.out_busy)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/pnete_dp.sv
// Datapath of the evaluator: marking and table memories, the compare stage,
// the enabled-vector accumulator and the output register. Depends on pnete_pkg.
module pnete_dp
	import pnete_pkg::*;
#(
	parameter int NUM_PLACES      = DEF_NUM_PLACES,
	parameter int NUM_TRANSITIONS = DEF_NUM_TRANSITIONS,
	parameter int TOKEN_BITS      = DEF_TOKEN_BITS,
	localparam int PW = (NUM_PLACES > 1) ? $clog2(NUM_PLACES) : 1,
	localparam int TW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1,
	localparam int LW = (NUM_PLACES * NUM_TRANSITIONS > 1) ?
		$clog2(NUM_PLACES * NUM_TRANSITIONS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [CFG_DW-1:0]  cfg_wdata,
	// item fields
	input  logic [OP_W-1:0]    opcode,
	input  logic [IDX_W-1:0]   place_index,
	input  logic [IDX_W-1:0]   transition_index,
	input  logic [VALUE_W-1:0] write_value,
	input  logic               arc_present,
	// sequencer
	input  pnete_cmd_t         cmd,
	input  logic [PW-1:0]      place,
	input  logic [TW-1:0]      trans,
	input  logic [LW-1:0]      lin,
	output pnete_sts_t         sts,
	// result
	input  logic               out_ready,
	output logic               out_valid,
	output logic [VEC_W-1:0]   enabled_vector,
	output logic [VEC_W-1:0]   newly_enabled,
	output logic [VEC_W-1:0]   newly_disabled,
	output logic               any_enabled
);

	localparam int DEPTH = NUM_PLACES * NUM_TRANSITIONS;
	localparam logic [PW-1:0] PLACE_LAST = PW'(NUM_PLACES - 1);

	// configuration registers
	logic [VEC_W-1:0] guard_q, event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q <= '1;
			event_q <= '1;
		end else if (cfg_we) begin
			if (cfg_addr == REG_GUARD_MASK) guard_q <= cfg_wdata;
			if (cfg_addr == REG_EVENT_MASK) event_q <= cfg_wdata;
		end
	end

	// captured item
	logic [OP_W-1:0]       op_q;
	logic [IDX_W-1:0]      pidx_q, tidx_q;
	logic [TOKEN_BITS-1:0] val_q;
	logic                  arc_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q   <= opcode;
			pidx_q <= place_index;
			tidx_q <= transition_index;
			val_q  <= TOKEN_BITS'(write_value);
			arc_q  <= arc_present;
		end
	end

	// item write decode
	logic          p_ok, t_ok;
	logic [PW-1:0] item_paddr;
	logic [LW-1:0] item_laddr;

	assign p_ok       = 32'(pidx_q) < NUM_PLACES;
	assign t_ok       = 32'(tidx_q) < NUM_TRANSITIONS;
	assign item_paddr = PW'(pidx_q);
	assign item_laddr = LW'(int'(tidx_q) * NUM_PLACES + int'(pidx_q));

	// memories
	logic [TOKEN_BITS-1:0] pre_mem  [DEPTH];
	logic                  inh_mem  [DEPTH];
	logic                  rdr_mem  [DEPTH];
	logic [TOKEN_BITS-1:0] mark_mem [NUM_PLACES];
	logic [TOKEN_BITS-1:0] init_mem [NUM_PLACES];

	// restore copy pipeline
	logic                  cpy_v_s1;
	logic [PW-1:0]         cpy_addr_s1;
	logic [TOKEN_BITS-1:0] cpy_data_s1;

	// table writes: clearing sweep or item write
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			pre_mem[lin] <= '0;
			inh_mem[lin] <= 1'b0;
			rdr_mem[lin] <= 1'b0;
		end else if (cmd.item_write && p_ok && t_ok) begin
			if (op_q == OP_PRE_WT) pre_mem[item_laddr] <= val_q;
			if (op_q == OP_INHIBIT) inh_mem[item_laddr] <= arc_q;
			if (op_q == OP_READER) rdr_mem[item_laddr] <= arc_q;
		end
	end

	// marking writes: clearing sweep, item write or restore copy
	always_ff @(posedge clk) begin
		if (cmd.clear)
			mark_mem[place] <= '0;
		else if (cmd.item_write && p_ok && op_q == OP_SET_MARK)
			mark_mem[item_paddr] <= val_q;
		else if (cpy_v_s1)
			mark_mem[cpy_addr_s1] <= cpy_data_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear)
			init_mem[place] <= '0;
		else if (cmd.item_write && p_ok && op_q == OP_INIT_MARK)
			init_mem[item_paddr] <= val_q;
	end

	// restore copy: read initial marking, write marking in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cpy_v_s1 <= 1'b0;
		else
			cpy_v_s1 <= cmd.copy_rd;
	end

	always_ff @(posedge clk) begin
		cpy_addr_s1 <= place;
		cpy_data_s1 <= init_mem[place];
	end

	// evaluation read stage
	logic                  ev_v_s1, first_s1, last_s1;
	logic [TW-1:0]         trans_s1;
	logic [TOKEN_BITS-1:0] pre_s1, mark_s1;
	logic                  inh_s1, rdr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ev_v_s1 <= 1'b0;
		else
			ev_v_s1 <= cmd.eval_rd;
	end

	always_ff @(posedge clk) begin
		first_s1 <= (place == '0);
		last_s1  <= (place == PLACE_LAST);
		trans_s1 <= trans;
		pre_s1   <= pre_mem[lin];
		inh_s1   <= inh_mem[lin];
		rdr_s1   <= rdr_mem[lin];
		mark_s1  <= mark_mem[place];
	end

	// compare stage and per-row accumulation
	logic             pass, row_ok, gate;
	logic             ok_q;
	logic [31:0]      tr_ext;
	logic [VEC_W-1:0] cur_q, last_q;

	assign pass   = (mark_s1 >= pre_s1) && !(inh_s1 && mark_s1 != '0) &&
	                !(rdr_s1 && mark_s1 == '0);
	assign row_ok = pass && (first_s1 || ok_q);
	assign tr_ext = 32'(trans_s1);
	assign gate   = guard_q[tr_ext[3:0]] && event_q[tr_ext[3:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q  <= 1'b0;
			cur_q <= '0;
		end else if (ev_v_s1) begin
			ok_q <= row_ok;
			// transitions above the reported width are evaluated but not kept
			if (last_s1 && tr_ext < 32'd16)
				cur_q[tr_ext[3:0]] <= row_ok && gate;
		end
	end

	// output register
	logic             out_valid_q;
	logic [VEC_W-1:0] en_q, ne_q, nd_q;
	logic             any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
			last_q      <= cur_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			en_q  <= cur_q;
			ne_q  <= cur_q & ~last_q;
			nd_q  <= last_q & ~cur_q;
			any_q <= |cur_q;
		end
	end

	assign sts.out_busy   = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign enabled_vector = en_q;
	assign newly_enabled  = ne_q;
	assign newly_disabled = nd_q;
	assign any_enabled    = any_q;

endmodule

>>> sv/petri_net_enabled_transition_evaluator.sv
// Top level of the Petri net enabled-transition evaluator.
// Depends on pnete_pkg, pnete_ctrl, pnete_dp and assert_macros.svh.

// Each item writes one marking place, initial-marking place, pre weight,
// inhibitor arc or reader arc, or restores the initial marking, and then
// re-evaluates every transition by walking the transition-by-place tables
// one entry per cycle through a single read port of each table memory.
// From acceptance to result an item passes the write step, the table walk,
// a drain step and the result step; an unused opcode writes nothing and
// skips the write step, and a restore replaces it with the copy through the
// marking memory's one write port and a settle step. One item is in work at
// a time; a finished result waits in the output register while the next
// item is taken. After reset a clearing pass over every table entry zeroes
// the memories before the first item is accepted; configuration writes are
// taken at any time.
`include "assert_macros.svh"

module petri_net_enabled_transition_evaluator
	import pnete_pkg::*;
#(
	parameter int NUM_PLACES      = DEF_NUM_PLACES,
	parameter int NUM_TRANSITIONS = DEF_NUM_TRANSITIONS,
	parameter int TOKEN_BITS      = DEF_TOKEN_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_AW-1:0]    cfg_addr,
	input  logic [CFG_DW-1:0]    cfg_wdata,
	// item stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // place_index, transition_index, write_value,
	                                        // arc_present, zero fill
	input  logic [OP_W-1:0]      s_tuser,  // opcode
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // enabled_vector, newly_enabled,
	                                        // newly_disabled, any_enabled, zero fill
);

	localparam int PW = (NUM_PLACES > 1) ? $clog2(NUM_PLACES) : 1;
	localparam int TW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
	localparam int LW = (NUM_PLACES * NUM_TRANSITIONS > 1) ?
		$clog2(NUM_PLACES * NUM_TRANSITIONS) : 1;

	pnete_cmd_t       cmd;
	pnete_sts_t       sts;
	logic [PW-1:0]    place;
	logic [TW-1:0]    trans;
	logic [LW-1:0]    lin;
	logic [VEC_W-1:0] enabled_vector, newly_enabled, newly_disabled;
	logic             any_enabled;

	pnete_ctrl #(
		.NUM_PLACES      (NUM_PLACES),
		.NUM_TRANSITIONS (NUM_TRANSITIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_opcode (s_tuser),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd),
		.place     (place),
		.trans     (trans),
		.lin       (lin)
	);

	pnete_dp #(
		.NUM_PLACES      (NUM_PLACES),
		.NUM_TRANSITIONS (NUM_TRANSITIONS),
		.TOKEN_BITS      (TOKEN_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.opcode           (s_tuser),
		.place_index      (s_tdata[3:0]),
		.transition_index (s_tdata[7:4]),
		.write_value      (s_tdata[23:8]),
		.arc_present      (s_tdata[24]),
		.cmd              (cmd),
		.place            (place),
		.trans            (trans),
		.lin              (lin),
		.sts              (sts),
		.out_ready        (m_tready),
		.out_valid        (m_tvalid),
		.enabled_vector   (enabled_vector),
		.newly_enabled    (newly_enabled),
		.newly_disabled   (newly_disabled),
		.any_enabled      (any_enabled)
	);

	// pack the result
	assign m_tdata = {7'd0, any_enabled, newly_disabled, newly_enabled, enabled_vector};

	// one item in work at a time
	`ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a waiting result is never overwritten
	`ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.result_load, !(m_tvalid && !m_tready))
	// sequencer issues at most one memory operation per cycle
	`ASSERT_ALWAYS(a_cmd_onehot, clk, arst_n,
		$onehot0({cmd.clear, cmd.item_write, cmd.copy_rd, cmd.eval_rd, cmd.result_load}))
	// summary flag agrees with the vector it summarizes
	`ASSERT_SAME(a_any_flag, clk, arst_n, m_tvalid, any_enabled == (enabled_vector != '0))

endmodule
